[hdl/mgemm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and IEEE-754 double helpers for the GEMM block.
// No dependencies.
package mgemm_pkg;

    // Beat carried by the command port
    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  elem_index;
        logic [63:0] elem_value;
    } t_in_beat;

    // Beat carried by the result port
    typedef struct packed {
        logic [5:0]  out_index;
        logic [63:0] out_value;
        logic        out_last;
    } t_out_beat;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_LOAD_C = 2'd2;
    localparam logic [1:0] OP_START  = 2'd3;

    localparam logic [2:0] CFG_TRANS_A = 3'd0;
    localparam logic [2:0] CFG_TRANS_B = 3'd1;
    localparam logic [2:0] CFG_ROWS_N  = 3'd2;
    localparam logic [2:0] CFG_COLS_K  = 3'd3;
    localparam logic [2:0] CFG_INNER_M = 3'd4;
    localparam logic [2:0] CFG_ALPHA   = 3'd5;
    localparam logic [2:0] CFG_BETA    = 3'd6;

    localparam logic [63:0] ALPHA_RESET = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] QNAN_DEF    = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_ALL1    = 11'h7FF;

    // Mantissa multiplier chain: 53-bit by 56-bit (padded), 14 bits per cell
    localparam int MANT_W    = 53;
    localparam int CELL_BITS = 14;
    localparam int N_CELLS   = 4;
    localparam int MB_W      = CELL_BITS * N_CELLS;
    localparam int PROD_W    = 2 * MANT_W;

    typedef logic signed [13:0] t_exp;

    typedef struct packed {
        logic              vld;
        logic [MANT_W-1:0] ma;
        logic [MB_W-1:0]   mb;
        logic [PROD_W-1:0] acc;
    } t_mul_stage;

    // Leading zeros of a non-zero byte
    function automatic logic [2:0] lzc8(input logic [7:0] v);
        logic [2:0] cnt;
        cnt = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (v[k]) cnt = 3'(7 - k);
        end
        return cnt;
    endfunction

    // Round to nearest even and pack. m has the unit bit at [55], guard at [2],
    // sticky folded into [1:0]. e is the biased exponent of that unit bit.
    function automatic logic [63:0] round_pack(input logic s, input t_exp e,
                                               input logic [55:0] m);
        logic [5:0]   sh;
        logic [119:0] wide;
        logic [55:0]  x;
        logic [10:0]  ef;
        logic         inc;
        logic [62:0]  mag;
        if (e >= 14'sd1) begin
            sh = 6'd0;
        end else if (e < -14'sd61) begin
            sh = 6'd63;
        end else begin
            sh = 6'(14'sd1 - e);
        end
        wide = {m, 64'd0} >> sh;
        x    = wide[119:64];
        x[0] = x[0] | (|wide[63:0]);
        ef   = (e >= 14'sd1) ? e[10:0] : 11'd0;
        inc  = x[2] & (x[1] | x[0] | x[3]);
        mag  = {ef, x[54:3]} + 63'(inc);
        if (e >= 14'sd2047) begin
            return {s, EXP_ALL1, 52'd0};
        end
        return {s, mag};
    endfunction

endpackage

[hdl/mgemm_mul_cell.sv]
`timescale 1ns / 1ps
// One cell of the mantissa multiplier chain: folds in one 14-bit digit.
// Depends on mgemm_pkg.
module mgemm_mul_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mgemm_pkg::t_mul_stage i_stage,
    output mgemm_pkg::t_mul_stage o_stage
);
    import mgemm_pkg::*;

    logic [MANT_W+CELL_BITS-1:0] w_pp;
    logic [PROD_W-1:0]           n_acc;

    assign w_pp  = i_stage.ma * i_stage.mb[MB_W-1 -: CELL_BITS];
    assign n_acc = {i_stage.acc[PROD_W-1-CELL_BITS:0], CELL_BITS'(0)}
                 + PROD_W'(w_pp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_stage.vld <= 1'b0;
        end else begin
            o_stage.vld <= i_stage.vld;
        end
        o_stage.ma  <= i_stage.ma;
        o_stage.mb  <= {i_stage.mb[MB_W-1-CELL_BITS:0], CELL_BITS'(0)};
        o_stage.acc <= n_acc;
    end

endmodule

[hdl/mgemm_fmul.sv]
`timescale 1ns / 1ps
// Double-precision multiplier: special cases, cell chain, normalise, round.
// Depends on mgemm_pkg and mgemm_mul_cell.
module mgemm_fmul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);
    import mgemm_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_MULT, M_NORM, M_ROUND} t_mstate;

    t_mstate           r_state;
    logic              r_done;
    logic [63:0]       r_res;
    logic              r_s;
    t_exp              r_e;
    logic [PROD_W-1:0] r_p;
    t_mul_stage        r_feed;
    t_mul_stage        w_st [N_CELLS+1];

    logic [10:0] w_ea, w_eb;
    logic        w_nan_a, w_nan_b, w_inf_a, w_inf_b, w_zero_a, w_zero_b;
    logic [2:0]  w_lz;

    assign w_ea     = i_a[62:52];
    assign w_eb     = i_b[62:52];
    assign w_nan_a  = (w_ea == EXP_ALL1) && (i_a[51:0] != '0);
    assign w_nan_b  = (w_eb == EXP_ALL1) && (i_b[51:0] != '0);
    assign w_inf_a  = (w_ea == EXP_ALL1) && (i_a[51:0] == '0);
    assign w_inf_b  = (w_eb == EXP_ALL1) && (i_b[51:0] == '0);
    assign w_zero_a = (i_a[62:0] == '0);
    assign w_zero_b = (i_b[62:0] == '0);
    assign w_lz     = lzc8(r_p[PROD_W-1 -: 8]);

    assign w_st[0] = r_feed;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        mgemm_mul_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_st[g]),
            .o_stage (w_st[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= M_IDLE;
            r_done     <= 1'b0;
            r_feed.vld <= 1'b0;
        end else begin
            r_done     <= 1'b0;
            r_feed.vld <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_go) begin
                        if (w_nan_a) begin
                            r_res  <= i_a | QUIET_BIT;
                            r_done <= 1'b1;
                        end else if (w_nan_b) begin
                            r_res  <= i_b | QUIET_BIT;
                            r_done <= 1'b1;
                        end else if ((w_inf_a && w_zero_b) || (w_zero_a && w_inf_b)) begin
                            r_res  <= QNAN_DEF;
                            r_done <= 1'b1;
                        end else if (w_inf_a || w_inf_b) begin
                            r_res  <= {i_a[63] ^ i_b[63], EXP_ALL1, 52'd0};
                            r_done <= 1'b1;
                        end else if (w_zero_a || w_zero_b) begin
                            r_res  <= {i_a[63] ^ i_b[63], 63'd0};
                            r_done <= 1'b1;
                        end else begin
                            r_s        <= i_a[63] ^ i_b[63];
                            // unit bit sits at the top of the product word
                            r_e        <= t_exp'((w_ea == '0) ? 11'd1 : w_ea)
                                        + t_exp'((w_eb == '0) ? 11'd1 : w_eb)
                                        - 14'sd1022;
                            r_feed.vld <= 1'b1;
                            r_feed.ma  <= {w_ea != '0, i_a[51:0]};
                            r_feed.mb  <= {(MB_W-MANT_W)'(0), w_eb != '0, i_b[51:0]};
                            r_feed.acc <= '0;
                            r_state    <= M_MULT;
                        end
                    end
                end
                M_MULT: begin
                    if (w_st[N_CELLS].vld) begin
                        r_p     <= w_st[N_CELLS].acc;
                        r_state <= M_NORM;
                    end
                end
                M_NORM: begin
                    priority if (r_p[PROD_W-1]) begin
                        r_state <= M_ROUND;
                    end else if (r_p[PROD_W-1 -: 8] == '0) begin
                        r_p <= r_p << 8;
                        r_e <= r_e - 14'sd8;
                    end else begin
                        r_p     <= r_p << w_lz;
                        r_e     <= r_e - t_exp'(w_lz);
                        r_state <= M_ROUND;
                    end
                end
                M_ROUND: begin
                    r_res   <= round_pack(r_s, r_e,
                                          {r_p[PROD_W-1 -: 55], |r_p[PROD_W-56:0]});
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[hdl/mgemm_fadd.sv]
`timescale 1ns / 1ps
// Double-precision adder: special cases, align and add, normalise, round.
// Depends on mgemm_pkg.
module mgemm_fadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);
    import mgemm_pkg::*;

    typedef enum logic [1:0] {A_IDLE, A_ALIGN, A_NORM, A_ROUND} t_astate;

    t_astate      r_state;
    logic         r_done;
    logic [63:0]  r_res;
    logic         r_s;
    logic         r_sub;
    t_exp         r_e;
    logic [10:0]  r_d;
    logic [55:0]  r_big;
    logic [55:0]  r_small;
    logic [55:0]  r_m;

    logic [10:0]  w_ea, w_eb;
    logic         w_nan_a, w_nan_b, w_inf_a, w_inf_b, w_zero_a, w_zero_b;
    logic         w_a_big;
    logic [63:0]  w_big, w_small;
    logic [10:0]  w_eg, w_es;
    logic [5:0]   w_sh;
    logic [119:0] w_wide;
    logic [55:0]  w_al;
    logic [56:0]  w_sum;
    logic [2:0]   w_lz;

    assign w_ea     = i_a[62:52];
    assign w_eb     = i_b[62:52];
    assign w_nan_a  = (w_ea == EXP_ALL1) && (i_a[51:0] != '0);
    assign w_nan_b  = (w_eb == EXP_ALL1) && (i_b[51:0] != '0);
    assign w_inf_a  = (w_ea == EXP_ALL1) && (i_a[51:0] == '0);
    assign w_inf_b  = (w_eb == EXP_ALL1) && (i_b[51:0] == '0);
    assign w_zero_a = (i_a[62:0] == '0);
    assign w_zero_b = (i_b[62:0] == '0);

    // magnitude order of two doubles is the order of their low 63 bits
    assign w_a_big = (i_a[62:0] >= i_b[62:0]);
    assign w_big   = w_a_big ? i_a : i_b;
    assign w_small = w_a_big ? i_b : i_a;
    assign w_eg    = (w_big[62:52] == '0) ? 11'd1 : w_big[62:52];
    assign w_es    = (w_small[62:52] == '0) ? 11'd1 : w_small[62:52];

    assign w_sh   = (r_d > 11'd63) ? 6'd63 : r_d[5:0];
    assign w_wide = {r_small, 64'd0} >> w_sh;
    assign w_al   = {w_wide[119:65], w_wide[64] | (|w_wide[63:0])};
    assign w_sum  = r_sub ? ({1'b0, r_big} - {1'b0, w_al})
                          : ({1'b0, r_big} + {1'b0, w_al});
    assign w_lz   = lzc8(r_m[55:48]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_go) begin
                        if (w_nan_a) begin
                            r_res  <= i_a | QUIET_BIT;
                            r_done <= 1'b1;
                        end else if (w_nan_b) begin
                            r_res  <= i_b | QUIET_BIT;
                            r_done <= 1'b1;
                        end else if (w_inf_a && w_inf_b && (i_a[63] != i_b[63])) begin
                            r_res  <= QNAN_DEF;
                            r_done <= 1'b1;
                        end else if (w_inf_a) begin
                            r_res  <= i_a;
                            r_done <= 1'b1;
                        end else if (w_inf_b) begin
                            r_res  <= i_b;
                            r_done <= 1'b1;
                        end else if (w_zero_a && w_zero_b) begin
                            r_res  <= {i_a[63] & i_b[63], 63'd0};
                            r_done <= 1'b1;
                        end else if (w_zero_a) begin
                            r_res  <= i_b;
                            r_done <= 1'b1;
                        end else if (w_zero_b) begin
                            r_res  <= i_a;
                            r_done <= 1'b1;
                        end else begin
                            r_s     <= w_big[63];
                            r_sub   <= i_a[63] ^ i_b[63];
                            r_e     <= t_exp'(w_eg);
                            r_d     <= w_eg - w_es;
                            r_big   <= {w_big[62:52] != '0, w_big[51:0], 3'd0};
                            r_small <= {w_small[62:52] != '0, w_small[51:0], 3'd0};
                            r_state <= A_ALIGN;
                        end
                    end
                end
                A_ALIGN: begin
                    priority if (w_sum == '0) begin
                        // exact cancellation gives +0 under nearest-even
                        r_res   <= 64'd0;
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end else if (w_sum[56]) begin
                        r_m     <= {w_sum[56:2], w_sum[1] | w_sum[0]};
                        r_e     <= r_e + 14'sd1;
                        r_state <= A_NORM;
                    end else begin
                        r_m     <= w_sum[55:0];
                        r_state <= A_NORM;
                    end
                end
                A_NORM: begin
                    priority if (r_m[55]) begin
                        r_state <= A_ROUND;
                    end else if (r_m[55:48] == '0) begin
                        r_m <= r_m << 8;
                        r_e <= r_e - 14'sd8;
                    end else begin
                        r_m     <= r_m << w_lz;
                        r_e     <= r_e - t_exp'(w_lz);
                        r_state <= A_ROUND;
                    end
                end
                A_ROUND: begin
                    r_res   <= round_pack(r_s, r_e, r_m);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[hdl/matrix_multiply_gemm.sv]
`timescale 1ns / 1ps
// GEMM C = alpha*op(A)*op(B) + beta*C, column-major, doubles. Top level.
// Depends on mgemm_pkg, mgemm_fmul, mgemm_fadd.
// Load beats are taken only while the block is not busy and may then follow back
// to back; results go out on o_valid for one cycle and cannot be stalled.
// A start beat holds busy until its last result beat goes out; one shared
// multiplier (four-cell multiplier chain plus a normalise loop) and one shared
// adder do all the arithmetic of a run.
// Synchronous active-low reset clears control and the registers to their
// reset values; the A, B and C stores are not cleared.
module matrix_multiply_gemm #(
    parameter int MAX_DIM = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mgemm_pkg::t_in_beat  i_in,
    output logic                 o_valid,
    output mgemm_pkg::t_out_beat o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);
    import mgemm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int IW    = $clog2(DEPTH);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = $clog2(MAX_DIM);

    // dimension register of 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic logic [DW-1:0] clamp_dim(input logic [3:0] v);
        if (v == 4'd0) return DW'(1);
        if (v > 4'(MAX_DIM)) return DW'(MAX_DIM);
        return DW'(v);
    endfunction

    typedef enum logic [2:0] {
        S_IDLE, S_RDAB, S_MULP, S_WMULP, S_WADDP, S_WALPHA, S_WBETA, S_WADDC
    } t_state;

    // configuration registers
    logic        r_trans_a, r_trans_b;
    logic [3:0]  r_rows_n, r_cols_k, r_inner_m;
    logic [63:0] r_alpha, r_beta;

    // run state, latched at start
    t_state          r_state;
    logic            r_ta, r_tb;
    logic [DW-1:0]   r_n, r_k, r_m;
    logic [63:0]     r_al, r_be;
    logic [CW-1:0]   r_i, r_j, r_x;
    logic [63:0]     r_d;
    logic [63:0]     r_r;

    logic            r_mul_go, r_add_go;
    logic [63:0]     r_mul_a, r_mul_b, r_add_a, r_add_b;
    logic            w_mul_done, w_add_done;
    logic [63:0]     w_mul_res, w_add_res;

    logic            r_valid;
    t_out_beat       r_out;

    // stores
    logic [63:0] a_mem [DEPTH];
    logic [63:0] b_mem [DEPTH];
    logic [63:0] c_mem [DEPTH];
    logic [63:0] r_a_rd, r_b_rd, r_c_rd;

    logic [IW-1:0] w_i, w_j, w_x, w_n, w_k, w_m;
    logic [IW-1:0] w_a_addr, w_b_addr, w_ci;
    logic          w_accept, w_load_ok;
    logic          w_beta_zero, w_x_last, w_i_last, w_j_last;
    logic          w_emit;
    logic [63:0]   w_emit_val;

    assign w_accept    = start && !busy;
    assign w_load_ok   = w_accept && (i_in.op != OP_START)
                      && ({1'b0, i_in.elem_index} < 7'(DEPTH));
    assign w_beta_zero = (r_be[62:0] == '0);

    assign w_i = IW'(r_i);
    assign w_j = IW'(r_j);
    assign w_x = IW'(r_x);
    assign w_n = IW'(r_n);
    assign w_k = IW'(r_k);
    assign w_m = IW'(r_m);

    // column-major addresses of the operands for the current (i, j, x)
    assign w_a_addr = r_ta ? (w_x + w_i * w_m) : (w_i + w_x * w_n);
    assign w_b_addr = r_tb ? (w_j + w_x * w_k) : (w_x + w_j * w_m);
    assign w_ci     = w_i + w_j * w_n;

    assign w_x_last = ((DW'(r_x) + DW'(1)) == r_m);
    assign w_i_last = ((DW'(r_i) + DW'(1)) == r_n);
    assign w_j_last = ((DW'(r_j) + DW'(1)) == r_k);

    // an element is finished after alpha*d when beta is zero, else after r+t
    assign w_emit     = ((r_state == S_WALPHA) && w_mul_done && w_beta_zero)
                     || ((r_state == S_WADDC) && w_add_done);
    assign w_emit_val = (r_state == S_WADDC) ? w_add_res : w_mul_res;

    mgemm_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mul_go),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    mgemm_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_add_go),
        .i_a     (r_add_a),
        .i_b     (r_add_b),
        .o_done  (w_add_done),
        .o_res   (w_add_res)
    );

    // stores: one write port and one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_load_ok && (i_in.op == OP_LOAD_A)) begin
            a_mem[i_in.elem_index[IW-1:0]] <= i_in.elem_value;
        end
        if (w_load_ok && (i_in.op == OP_LOAD_B)) begin
            b_mem[i_in.elem_index[IW-1:0]] <= i_in.elem_value;
        end
        if (w_load_ok && (i_in.op == OP_LOAD_C)) begin
            c_mem[i_in.elem_index[IW-1:0]] <= i_in.elem_value;
        end else if (w_emit) begin
            c_mem[w_ci] <= w_emit_val;
        end
        r_a_rd <= a_mem[w_a_addr];
        r_b_rd <= b_mem[w_b_addr];
        r_c_rd <= c_mem[w_ci];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_a <= 1'b0;
            r_trans_b <= 1'b0;
            r_rows_n  <= 4'd1;
            r_cols_k  <= 4'd1;
            r_inner_m <= 4'd1;
            r_alpha   <= ALPHA_RESET;
            r_beta    <= 64'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRANS_A: r_trans_a <= i_cfg_data[0];
                CFG_TRANS_B: r_trans_b <= i_cfg_data[0];
                CFG_ROWS_N:  r_rows_n  <= i_cfg_data[3:0];
                CFG_COLS_K:  r_cols_k  <= i_cfg_data[3:0];
                CFG_INNER_M: r_inner_m <= i_cfg_data[3:0];
                CFG_ALPHA:   r_alpha   <= i_cfg_data;
                CFG_BETA:    r_beta    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: rows outer, columns inner, dot product over x
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mul_go <= 1'b0;
            r_add_go <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_add_go <= 1'b0;
            r_valid  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_in.op == OP_START)) begin
                        r_ta    <= r_trans_a;
                        r_tb    <= r_trans_b;
                        r_n     <= clamp_dim(r_rows_n);
                        r_k     <= clamp_dim(r_cols_k);
                        r_m     <= clamp_dim(r_inner_m);
                        r_al    <= r_alpha;
                        r_be    <= r_beta;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_x     <= '0;
                        r_d     <= 64'd0;
                        r_state <= S_RDAB;
                    end
                end
                S_RDAB: r_state <= S_MULP;
                S_MULP: begin
                    r_mul_go <= 1'b1;
                    r_mul_a  <= r_a_rd;
                    r_mul_b  <= r_b_rd;
                    r_state  <= S_WMULP;
                end
                S_WMULP: begin
                    if (w_mul_done) begin
                        r_add_go <= 1'b1;
                        r_add_a  <= r_d;
                        r_add_b  <= w_mul_res;
                        r_state  <= S_WADDP;
                    end
                end
                S_WADDP: begin
                    if (w_add_done) begin
                        r_d <= w_add_res;
                        if (w_x_last) begin
                            r_mul_go <= 1'b1;
                            r_mul_a  <= r_al;
                            r_mul_b  <= w_add_res;
                            r_state  <= S_WALPHA;
                        end else begin
                            r_x     <= CW'(r_x + 1'b1);
                            r_state <= S_RDAB;
                        end
                    end
                end
                S_WALPHA: begin
                    // old C was read long ago at this index; it is still current
                    if (w_mul_done && !w_beta_zero) begin
                        r_r      <= w_mul_res;
                        r_mul_go <= 1'b1;
                        r_mul_a  <= r_be;
                        r_mul_b  <= r_c_rd;
                        r_state  <= S_WBETA;
                    end
                end
                S_WBETA: begin
                    if (w_mul_done) begin
                        r_add_go <= 1'b1;
                        r_add_a  <= r_r;
                        r_add_b  <= w_mul_res;
                        r_state  <= S_WADDC;
                    end
                end
                S_WADDC: ;
                default: r_state <= S_IDLE;
            endcase

            if (w_emit) begin
                r_valid           <= 1'b1;
                r_out.out_index   <= 6'(w_ci);
                r_out.out_value   <= w_emit_val;
                r_out.out_last    <= w_i_last && w_j_last;
                r_x               <= '0;
                r_d               <= 64'd0;
                if (w_j_last) begin
                    r_j <= '0;
                    r_i <= CW'(r_i + 1'b1);
                end else begin
                    r_j <= CW'(r_j + 1'b1);
                end
                r_state <= (w_i_last && w_j_last) ? S_IDLE : S_RDAB;
            end
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    // a result beat only follows a cycle of work
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without a run in progress");

    // the last beat of a run leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.out_last) |-> !busy)
        else $error("run still busy after its last beat");

    // the shared units are used one at a time
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_add_done))
        else $error("multiplier and adder finished together");

    // a start beat opens a run
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.op == OP_START)) |=> busy)
        else $error("start beat did not open a run");

endmodule

[bench/matrix_multiply_gemm_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply_gemm: directed table, then random GEMM phases.
// Depends on mgemm_pkg and the matrix_multiply_gemm RTL; double maths via SV real.
module matrix_multiply_gemm_tb;
    import mgemm_pkg::*;

    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int SETTLE      = 60;    // cycles of quiet after the last expected beat
    localparam int RAND_ITEMS  = 200;

    typedef enum logic {ROW_CFG, ROW_BEAT} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  sel;       // register index or command op
        logic [5:0]  idx;
        logic [63:0] data;      // register value or element bits
        bit          has_exp;   // single typed result at index 0
        logic [63:0] exp_bits;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_beat    i_in = '0;
    logic        o_valid;
    t_out_beat   o_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    matrix_multiply_gemm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Shadow of the block: registers and the three element stores
    // ---------------------------------------------------------------
    logic        sh_trans_a, sh_trans_b;
    logic [3:0]  sh_rows, sh_cols, sh_inner;
    logic [63:0] sh_alpha, sh_beta;
    real         a_mem [64];
    real         b_mem [64];
    real         c_mem [64];

    t_out_beat   pending_c [$];     // C beats still owed by the block
    int          n_errors = 0;
    int          n_items  = 0;
    bit          quiet_tail = 0;    // no gaps towards the end of the run

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic int clamp_dim(input logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > 4'd8) return 8;
        return int'(v);
    endfunction

    function automatic bit is_nan(input logic [63:0] b);
        return (b[62:52] == EXP_ALL1) && (b[51:0] != '0);
    endfunction

    // Work out every C beat a start produces and update the C shadow.
    // Sum runs in increasing inner order from +0.0; zero beta skips old C.
    task automatic gemm_predict(input bit typed, input logic [63:0] typed_bits);
        int     n, k, m, ai, bi, ci;
        real    acc, r, alpha, beta;
        t_out_beat ob;
        n = clamp_dim(sh_rows);
        k = clamp_dim(sh_cols);
        m = clamp_dim(sh_inner);
        alpha = $bitstoreal(sh_alpha);
        beta  = $bitstoreal(sh_beta);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < k; j++) begin
                acc = 0.0;
                ci  = (i + j * n) & 63;
                for (int x = 0; x < m; x++) begin
                    ai  = sh_trans_a ? (x + i * m) : (i + x * n);
                    bi  = sh_trans_b ? (j + x * k) : (x + j * m);
                    acc = acc + a_mem[ai & 63] * b_mem[bi & 63];
                end
                r = alpha * acc;
                if (!(beta == 0.0)) r = r + beta * c_mem[ci];
                c_mem[ci]    = r;
                ob.out_index = 6'(ci);
                ob.out_value = typed ? typed_bits : $realtobits(r);
                ob.out_last  = (i == n - 1) && (j == k - 1);
                pending_c.push_back(ob);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: every strobed beat is matched to the oldest one owed
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid) begin
            if (pending_c.size() == 0) begin
                report($sformatf("unexpected beat idx %0d", o_out.out_index));
            end else begin
                want = pending_c.pop_front();
                if (o_out.out_index !== want.out_index)
                    report($sformatf("index %0d, want %0d", o_out.out_index, want.out_index));
                if (o_out.out_last !== want.out_last)
                    report($sformatf("last %0b at idx %0d", o_out.out_last, want.out_index));
                // Any NaN payload is accepted where a NaN is due
                if (is_nan(want.out_value) ? !is_nan(o_out.out_value)
                                           : (o_out.out_value !== want.out_value))
                    report($sformatf("value %h, want %h at idx %0d",
                                     o_out.out_value, want.out_value, want.out_index));
            end
        end
    end

    // Watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("matrix_multiply_gemm_tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers. All run from the posedge, driving with NBAs.
    // ---------------------------------------------------------------

    // Hold a beat on the command port until the block takes it
    task automatic send_beat(input logic [1:0] op, input logic [5:0] idx,
                             input logic [63:0] val, input bit typed,
                             input logic [63:0] typed_bits);
        t_in_beat b;
        int       gap;
        b.op = op;
        b.elem_index = idx;
        b.elem_value = val;
        start <= 1'b1;
        i_in  <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
        // taken at this edge
        case (op)
            OP_LOAD_A: a_mem[idx] = $bitstoreal(val);
            OP_LOAD_B: b_mem[idx] = $bitstoreal(val);
            OP_LOAD_C: c_mem[idx] = $bitstoreal(val);
            default:   gemm_predict(typed, typed_bits);
        endcase
        n_items++;
        if (!quiet_tail && ($urandom_range(0, 3) == 0)) begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            i_in  <= t_in_beat'({$urandom(), $urandom(), $urandom()});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain the result queue and let the block settle before a register write
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_c.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One register write; the caller drops the write enable afterwards
    task automatic cfg_write(input logic [2:0] sel, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (sel)
            CFG_TRANS_A: sh_trans_a = val[0];
            CFG_TRANS_B: sh_trans_b = val[0];
            CFG_ROWS_N:  sh_rows    = val[3:0];
            CFG_COLS_K:  sh_cols    = val[3:0];
            CFG_INNER_M: sh_inner   = val[3:0];
            CFG_ALPHA:   sh_alpha   = val;
            default:     sh_beta    = val;
        endcase
    endtask

    // Random double: mostly tame normals so sums stay finite, plus the
    // odd special value and fully random bit patterns
    function automatic logic [63:0] rand_dbl();
        logic [63:0] v;
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5:
                v = {1'($urandom()), 11'($urandom_range(1013, 1033)),
                     $urandom(), 20'($urandom())};
            6:  v = {1'($urandom()), 63'd0};                               // +/- zero
            7:  v = {$urandom(), $urandom()};                              // any bits
            8:  v = $realtobits(real'($urandom_range(0, 16)) - 8.0);
            9:  v = {1'($urandom()), EXP_ALL1, 52'd0};                     // infinity
            10: v = {1'($urandom()), 11'd0, 20'($urandom()), $urandom()};  // subnormal
            default: v = {1'($urandom()), 11'h7FE, 52'hF_FFFF_FFFF_FFFF};  // huge
        endcase
        return v;
    endfunction

    // Mostly small sizes, now and then the extremes (0 and 15 clamp)
    function automatic logic [63:0] rand_dim();
        case ($urandom_range(0, 19))
            0:       return 64'd0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return 64'd8;
            default: return 64'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic logic [63:0] rand_scale();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return {1'b1, 63'd0};
            2:       return $realtobits(1.0);
            3:       return QNAN_DEF;
            default: return rand_dbl();
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Directed table: beats and register writes, walked in order
    // ---------------------------------------------------------------
    localparam int N_DIR = 24;
    t_row dir_tab [N_DIR];

    function automatic t_row row_cfg(input logic [2:0] sel, input logic [63:0] val);
        t_row r;
        r.kind = ROW_CFG; r.sel = sel; r.idx = '0; r.data = val;
        r.has_exp = 0; r.exp_bits = '0;
        return r;
    endfunction

    function automatic t_row row_beat(input logic [1:0] op, input logic [5:0] idx,
                                      input logic [63:0] val, input bit has_exp,
                                      input logic [63:0] exp_bits);
        t_row r;
        r.kind = ROW_BEAT; r.sel = 3'(op); r.idx = idx; r.data = val;
        r.has_exp = has_exp; r.exp_bits = exp_bits;
        return r;
    endfunction

    initial begin
        logic [63:0] v;
        bit          dims_big;
        int          n_loads;

        // Register values straight after reset: 1x1x1, alpha 1.0, beta +0.0
        dir_tab[0]  = row_beat(OP_LOAD_A, 6'd0, 64'h4000_0000_0000_0000, 0, '0);  // 2.0
        dir_tab[1]  = row_beat(OP_LOAD_B, 6'd0, 64'h4008_0000_0000_0000, 0, '0);  // 3.0
        dir_tab[2]  = row_beat(OP_START,  6'd0, '0, 1, 64'h4018_0000_0000_0000);  // 6.0
        // Zero beta must not read a NaN in C
        dir_tab[3]  = row_beat(OP_LOAD_C, 6'd0, 64'h7FF8_0000_0000_0000, 0, '0);
        dir_tab[4]  = row_beat(OP_START,  6'd0, '0, 1, 64'h4018_0000_0000_0000);
        // Minus zero beta skips C as well
        dir_tab[5]  = row_cfg(CFG_BETA, 64'h8000_0000_0000_0000);
        dir_tab[6]  = row_beat(OP_LOAD_C, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, '0);
        dir_tab[7]  = row_beat(OP_START,  6'd0, '0, 1, 64'h4018_0000_0000_0000);
        // NaN beta is not zero: old C is read and the NaN comes through
        dir_tab[8]  = row_cfg(CFG_BETA, QNAN_DEF);
        dir_tab[9]  = row_beat(OP_START,  6'd0, '0, 1, 64'h7FF8_0000_0000_0000);
        // Alpha of minus infinity with a finite product
        dir_tab[10] = row_cfg(CFG_BETA, 64'd0);
        dir_tab[11] = row_cfg(CFG_ALPHA, 64'hFFF0_0000_0000_0000);
        dir_tab[12] = row_beat(OP_START,  6'd0, '0, 1, 64'hFFF0_0000_0000_0000);
        // Both transposes, dimensions out of range: 0 -> 1, 15 -> 8, 9 -> 8
        dir_tab[13] = row_beat(OP_LOAD_A, 6'd0, 64'h0000_0000_0000_0000, 0, '0);
        dir_tab[14] = row_beat(OP_LOAD_B, 6'd63, 64'h3FF8_0000_0000_0000, 0, '0);
        dir_tab[15] = row_cfg(CFG_TRANS_A, 64'hFFFF_FFFF_FFFF_FFFF);
        dir_tab[16] = row_cfg(CFG_TRANS_B, 64'd1);
        dir_tab[17] = row_cfg(CFG_ROWS_N, 64'd0);
        dir_tab[18] = row_cfg(CFG_COLS_K, 64'hFFFF_FFFF_FFFF_FFFF);
        dir_tab[19] = row_cfg(CFG_INNER_M, 64'd9);
        dir_tab[20] = row_cfg(CFG_ALPHA, 64'h3FF0_0000_0000_0000);
        dir_tab[21] = row_beat(OP_START,  6'd0, '0, 0, '0);
        // Largest case: 8x8x8 with beta 1.0, no transposes
        dir_tab[22] = row_cfg(CFG_ROWS_N, 64'd8);
        dir_tab[23] = row_beat(OP_START,  6'd0, '0, 0, '0);

        // Reset values of the shadow registers
        sh_trans_a = 0; sh_trans_b = 0;
        sh_rows = 4'd1; sh_cols = 4'd1; sh_inner = 4'd1;
        sh_alpha = ALPHA_RESET; sh_beta = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill all three stores so no entry is ever read before it is written
        for (int s = 0; s < 3; s++) begin
            for (int e = 0; e < 64; e++) begin
                send_beat(2'(s), 6'(e), rand_dbl(), 0, '0);
            end
        end

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_tab[r].sel, dir_tab[r].data);
                // 8x8x8 phase wants the other dimensions and beta set too
                if (r == 22) begin
                    cfg_write(CFG_TRANS_A, 64'd0);
                    cfg_write(CFG_TRANS_B, 64'd0);
                    cfg_write(CFG_COLS_K, 64'd8);
                    cfg_write(CFG_INNER_M, 64'd8);
                    cfg_write(CFG_BETA, $realtobits(1.0));
                end
                i_cfg_we <= 1'b0;
                @(posedge i_clk);
            end else begin
                send_beat(dir_tab[r].sel[1:0], dir_tab[r].idx, dir_tab[r].data,
                          dir_tab[r].has_exp, dir_tab[r].exp_bits);
            end
        end

        // Random phases: new settings, a burst of loads, then a start
        n_items = 0;
        while (n_items < RAND_ITEMS) begin
            if (n_items > RAND_ITEMS - 60) quiet_tail = 1;
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                dims_big = ($urandom_range(0, 15) == 0);
                cfg_write(CFG_TRANS_A, {$urandom(), $urandom()});
                cfg_write(CFG_TRANS_B, {$urandom(), $urandom()});
                cfg_write(CFG_ROWS_N,  dims_big ? 64'd8 : rand_dim());
                cfg_write(CFG_COLS_K,  dims_big ? 64'd8 : rand_dim());
                cfg_write(CFG_INNER_M, dims_big ? 64'd8 : rand_dim());
                cfg_write(CFG_ALPHA,   rand_scale());
                cfg_write(CFG_BETA,    rand_scale());
                i_cfg_we <= 1'b0;
                @(posedge i_clk);
            end
            n_loads = $urandom_range(0, 12);
            for (int l = 0; l < n_loads; l++) begin
                v = rand_dbl();
                send_beat(2'($urandom_range(0, 2)), 6'($urandom_range(0, 63)), v, 0, '0);
            end
            // start beats carry junk in the other fields
            send_beat(OP_START, 6'($urandom()), {$urandom(), $urandom()}, 0, '0);
        end

        wait_idle();
        if (n_errors == 0) begin
            $display("matrix_multiply_gemm_tb: done, clean");
        end else begin
            $display("matrix_multiply_gemm_tb: done, errors");
        end
        $finish;
    end

endmodule
